/* hw/rtl/yuvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// Shared types and constants of the BT.709 limited-range YUV to RGBA core.
// ----------------------------------------------------------------------------
package yuvrgb_pkg;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 13;
  localparam int MODE_W       = 2;
  localparam int LINE_WIDTH_W = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_CHROMA_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH  = 1'b1;

  localparam logic [MODE_W-1:0] MODE_444 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_422 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_420 = 2'd2;

  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 13'd1920;
  localparam int MIN_LINE_WIDTH = 2;

  // coefficients in thousandths
  localparam int COEF_Y_MILLI  = 1164;
  localparam int COEF_RV_MILLI = 1793;
  localparam int COEF_GU_MILLI = 213;
  localparam int COEF_GV_MILLI = 533;
  localparam int COEF_BU_MILLI = 2112;

  localparam int LUMA_OFFSET   = 16;
  localparam int CHROMA_OFFSET = 128;
  localparam int CHANNEL_MAX   = 255;

endpackage

/* hw/rtl/yuv_to_rgba_bt709_converter_core.sv */
// ----------------------------------------------------------------------------
// yuv_to_rgba_bt709_converter_core
// Converts a raster stream of YCbCr pixels to opaque 8-bit RGBA using BT.709
// limited-range coefficients with 4:4:4, 4:2:2 or 4:2:0 chroma replication.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns an RGBA pixel for each accepted one,
// through the input stage and then the result register; a new item is taken in
// every cycle in which the result side does not stall, since the input stage and
// the result register advance together. The first stage resolves the chroma pair
// from the input, the held even-column pair, or the half-width line store
// ((MAX_WIDTH+1)/2 entries of 16 bits, at most one write and one registered read
// per item); the second stage is the constant-coefficient matrix and clamp. The
// line store needs no clearing after reset: in 4:2:0 the odd row reads only
// entries its even row wrote. Write configuration only while the stream is idle.
module yuv_to_rgba_bt709_converter_core #(
  parameter int MAX_WIDTH      = 4096,
  parameter int COEF_FRAC_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  yuvrgb_pkg::pixel_t                 pixel,
  output logic                               rgba_valid,
  input  logic                               rgba_ready,
  output yuvrgb_pkg::rgba_t                  rgba,
  input  logic                               cfg_write,
  input  logic [yuvrgb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [yuvrgb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import yuvrgb_pkg::*;

  logic   stage_valid;
  logic   advance;
  logic   accept;
  pixel_t yuv;

  assign advance     = ~rgba_valid | rgba_ready;
  assign pixel_ready = ~stage_valid | advance;
  assign accept      = pixel_valid & pixel_ready;

  yuvrgb_chroma #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_chroma (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pixel     (pixel),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .yuv       (yuv)
  );

  yuvrgb_matrix #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_matrix (
    .clk  (clk),
    .load (advance & stage_valid),
    .yuv  (yuv),
    .rgba (rgba)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      rgba_valid  <= 1'b0;
    end else begin
      if (pixel_ready) begin
        stage_valid <= pixel_valid;
      end
      if (advance) begin
        rgba_valid <= stage_valid;
      end
    end
  end

  a_accept_fills_stage : assert property (@(posedge clk) disable iff (rst)
    accept |=> stage_valid)
    else $error("accepted item did not reach the input stage");

  a_stage_moves_out : assert property (@(posedge clk) disable iff (rst)
    stage_valid && advance |=> rgba_valid)
    else $error("staged item was not moved to the result register");

  a_full_stall_blocks : assert property (@(posedge clk) disable iff (rst)
    stage_valid && rgba_valid && !rgba_ready |-> !pixel_ready)
    else $error("input taken while both stages are stalled");

  a_opaque_alpha : assert property (@(posedge clk) disable iff (rst)
    rgba_valid |-> rgba.alpha == 8'(CHANNEL_MAX))
    else $error("result alpha is not opaque");

endmodule

/* hw/rtl/yuvrgb_chroma.sv */
// ----------------------------------------------------------------------------
// yuvrgb_chroma
// Configuration registers, raster counters, held chroma and the half-width
// chroma line store; registers one pixel with its resolved chroma pair.
// ----------------------------------------------------------------------------
module yuvrgb_chroma #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  yuvrgb_pkg::pixel_t                 pixel,
  input  logic                               cfg_write,
  input  logic [yuvrgb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [yuvrgb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output yuvrgb_pkg::pixel_t                 yuv
);
  import yuvrgb_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int DEPTH  = (MAX_WIDTH + 1) / 2;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [MODE_W-1:0]       chroma_mode;
  logic [LINE_WIDTH_W-1:0] line_width;
  logic [COL_W-1:0]        column_count;
  logic                    odd_row;
  logic [15:0]             held_chroma;
  logic                    use_store;
  logic [15:0]             sel_chroma;
  logic [15:0]             store_rd;
  logic [7:0]              luma_q;
  logic [15:0]             store [DEPTH];

  logic [15:0]       cin;
  logic              even_col;
  logic [ADDR_W-1:0] idx;
  logic [31:0]       eff_width;
  logic              wrap;
  logic [15:0]       held_next;
  logic [15:0]       sel_next;
  logic              use_store_next;
  logic              store_we;
  logic [15:0]       chroma;

  assign cin      = {pixel.chroma_blue, pixel.chroma_red};
  assign even_col = ~column_count[0];
  assign idx      = ADDR_W'(column_count >> 1);

  always_comb begin
    if (32'(line_width) < 32'(MIN_LINE_WIDTH)) begin
      eff_width = 32'(MIN_LINE_WIDTH);
    end else if (32'(line_width) > 32'(MAX_WIDTH)) begin
      eff_width = 32'(MAX_WIDTH);
    end else begin
      eff_width = 32'(line_width);
    end
  end

  assign wrap = (32'(column_count) + 32'd1) >= eff_width;

  always_comb begin
    held_next      = held_chroma;
    sel_next       = cin;
    use_store_next = 1'b0;
    store_we       = 1'b0;
    case (chroma_mode)
      MODE_422: begin
        if (even_col) begin
          held_next = cin;
        end
        sel_next = even_col ? cin : held_chroma;
      end
      MODE_420: begin
        if (odd_row) begin
          use_store_next = 1'b1;
        end else begin
          if (even_col) begin
            held_next = cin;
            store_we  = 1'b1;
          end
          sel_next = even_col ? cin : held_chroma;
        end
      end
      default: begin
        sel_next = cin;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chroma_mode  <= MODE_444;
      line_width   <= LINE_WIDTH_RESET;
      column_count <= '0;
      odd_row      <= 1'b0;
      held_chroma  <= '0;
      use_store    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_CHROMA_MODE: chroma_mode <= cfg_data[MODE_W-1:0];
          REG_LINE_WIDTH:  line_width  <= cfg_data[LINE_WIDTH_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        held_chroma <= held_next;
        use_store   <= use_store_next;
        if (wrap) begin
          column_count <= '0;
          odd_row      <= ~odd_row;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sel_chroma <= sel_next;
      luma_q     <= pixel.luma;
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (accept) begin
      if (store_we) begin
        store[idx] <= cin;
      end
      store_rd <= store[idx];
    end
  end

  assign chroma = use_store ? store_rd : sel_chroma;
  assign yuv    = '{luma: luma_q, chroma_blue: chroma[15:8], chroma_red: chroma[7:0]};

endmodule

/* hw/rtl/yuvrgb_matrix.sv */
// ----------------------------------------------------------------------------
// yuvrgb_matrix
// BT.709 limited-range color matrix in fixed point with clamping to 8 bits;
// the result is registered.
// ----------------------------------------------------------------------------
module yuvrgb_matrix #(
  parameter int COEF_FRAC_BITS = 10
) (
  input  logic               clk,
  input  logic               load,
  input  yuvrgb_pkg::pixel_t yuv,
  output yuvrgb_pkg::rgba_t  rgba
);
  import yuvrgb_pkg::*;

  localparam int ACC_W = COEF_FRAC_BITS + 14;

  localparam longint K0 = ((64'(COEF_Y_MILLI)  << COEF_FRAC_BITS) + 500) / 1000;
  localparam longint K1 = ((64'(COEF_RV_MILLI) << COEF_FRAC_BITS) + 500) / 1000;
  localparam longint K2 = ((64'(COEF_GU_MILLI) << COEF_FRAC_BITS) + 500) / 1000;
  localparam longint K3 = ((64'(COEF_GV_MILLI) << COEF_FRAC_BITS) + 500) / 1000;
  localparam longint K4 = ((64'(COEF_BU_MILLI) << COEF_FRAC_BITS) + 500) / 1000;

  localparam logic signed [ACC_W-1:0] C0 = ACC_W'(K0);
  localparam logic signed [ACC_W-1:0] C1 = ACC_W'(K1);
  localparam logic signed [ACC_W-1:0] C2 = ACC_W'(K2);
  localparam logic signed [ACC_W-1:0] C3 = ACC_W'(K3);
  localparam logic signed [ACC_W-1:0] C4 = ACC_W'(K4);

  function automatic logic [7:0] to_channel(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-COEF_FRAC_BITS-1:0] whole;
    begin
      whole = acc[ACC_W-1:COEF_FRAC_BITS];
      if (acc[ACC_W-1]) begin
        to_channel = '0;
      end else if (|whole[ACC_W-COEF_FRAC_BITS-1:8]) begin
        to_channel = 8'(CHANNEL_MAX);
      end else begin
        to_channel = whole[7:0];
      end
    end
  endfunction

  logic signed [ACC_W-1:0] yd;
  logic signed [ACC_W-1:0] ud;
  logic signed [ACC_W-1:0] vd;
  logic signed [ACC_W-1:0] yt;
  logic signed [ACC_W-1:0] r_acc;
  logic signed [ACC_W-1:0] g_acc;
  logic signed [ACC_W-1:0] b_acc;

  assign yd = ACC_W'(signed'({1'b0, yuv.luma}))        - ACC_W'(LUMA_OFFSET);
  assign ud = ACC_W'(signed'({1'b0, yuv.chroma_blue})) - ACC_W'(CHROMA_OFFSET);
  assign vd = ACC_W'(signed'({1'b0, yuv.chroma_red}))  - ACC_W'(CHROMA_OFFSET);

  assign yt    = C0 * yd;
  assign r_acc = yt + C1 * vd;
  assign g_acc = yt - C2 * ud - C3 * vd;
  assign b_acc = yt + C4 * ud;

  always_ff @(posedge clk) begin
    if (load) begin
      rgba.red   <= to_channel(r_acc);
      rgba.green <= to_channel(g_acc);
      rgba.blue  <= to_channel(b_acc);
      rgba.alpha <= 8'(CHANNEL_MAX);
    end
  end

endmodule
